[hw/rtl/pku_pkg.sv]
// pku_pkg: shared types and constants of the pin keypad unscramble block
// no dependencies; used by pku_cfg_if and every module of the block
package pku_pkg;

	localparam int unsigned TAB_SIZE  = 10;
	localparam int unsigned PIN_LEN   = 4;
	localparam int unsigned NUM_STEPS = 9;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_NINE = 8'd57;

	localparam logic [31:0] LCG_MULTIPLIER_RST = 32'h0000_3498;
	localparam logic [31:0] LCG_INCREMENT_RST  = 32'h0088_1234;

	typedef logic [TAB_SIZE-1:0][3:0] tab_t;
	typedef logic [PIN_LEN-1:0][7:0]  digits_t;
	typedef logic [PIN_LEN-1:0][5:0]  plain_t;

	localparam tab_t TAB_IDENTITY = {4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};

	typedef enum logic [0:0] {
		CFG_LCG_MULTIPLIER = 1'b0,
		CFG_LCG_INCREMENT  = 1'b1
	} cfg_idx_e;

	typedef struct packed {
		logic [31:0] seed;
		digits_t     digits;
		tab_t        tab;
	} item_t;

endpackage

[hw/rtl/pku_cfg_if.sv]
// pku_cfg_if: configuration write channel, register index and write data
// depends on pku_pkg for the register index type
interface pku_cfg_if;
	logic              valid;
	logic              ready;
	pku_pkg::cfg_idx_e index;
	logic [31:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/pku_req_if.sv]
// pku_req_if: request channel carrying the seed and four received pin characters
// no dependencies
interface pku_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;
	logic [7:0]  scrambled_digit_0;
	logic [7:0]  scrambled_digit_1;
	logic [7:0]  scrambled_digit_2;
	logic [7:0]  scrambled_digit_3;

	modport source (output valid, output seed, output scrambled_digit_0,
		output scrambled_digit_1, output scrambled_digit_2, output scrambled_digit_3,
		input ready);
	modport sink (input valid, input seed, input scrambled_digit_0,
		input scrambled_digit_1, input scrambled_digit_2, input scrambled_digit_3,
		output ready);
endinterface

[hw/rtl/pku_rsp_if.sv]
// pku_rsp_if: response channel carrying four plain pin digits and the bad digit flag
// no dependencies
interface pku_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] plain_digit_0;
	logic [5:0] plain_digit_1;
	logic [5:0] plain_digit_2;
	logic [5:0] plain_digit_3;
	logic       bad_digit;

	modport source (output valid, output plain_digit_0, output plain_digit_1,
		output plain_digit_2, output plain_digit_3, output bad_digit, input ready);
	modport sink (input valid, input plain_digit_0, input plain_digit_1,
		input plain_digit_2, input plain_digit_3, input bad_digit, output ready);
endinterface

[hw/rtl/pku_cfg_regs.sv]
// pku_cfg_regs: generator multiplier and increment registers
// depends on pku_pkg and pku_cfg_if
module pku_cfg_regs (
	input  logic        clk,
	input  logic        arst_n,
	pku_cfg_if.sink     cfg,
	output logic [31:0] lcg_multiplier,
	output logic [31:0] lcg_increment
);

	logic [31:0] mul_q;
	logic [31:0] inc_q;

	assign cfg.ready      = 1'b1;
	assign lcg_multiplier = mul_q;
	assign lcg_increment  = inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q <= pku_pkg::LCG_MULTIPLIER_RST;
			inc_q <= pku_pkg::LCG_INCREMENT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pku_pkg::CFG_LCG_MULTIPLIER: mul_q <= cfg.data;
				pku_pkg::CFG_LCG_INCREMENT:  inc_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/pku_shuffle_step.sv]
// pku_shuffle_step: one shuffle step in three stages: generator, residue fold, reduce and swap
// depends on pku_pkg
module pku_shuffle_step #(
	parameter int unsigned STEP = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     lcg_multiplier,
	input  logic [31:0]     lcg_increment,
	input  logic            in_valid,
	output logic            in_ready,
	input  pku_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output pku_pkg::item_t  out_item
);

	localparam int unsigned M     = STEP + 1;
	localparam int unsigned R     = (65536 + M - 1) / M;
	localparam int unsigned NIBS  = 8;

	logic           valid_s1, valid_s2, valid_s3;
	logic           rdy1, rdy2, rdy3;
	pku_pkg::item_t item_s1, item_s2, item_s3;
	logic [10:0]    fold_s2;

	logic [NIBS-1:0][7:0] term;
	logic [10:0]          fold_sum;
	logic [26:0]          recip_prod;
	logic [10:0]          quot;
	logic [10:0]          rem;
	logic [3:0]           pos;
	pku_pkg::tab_t        tab_swp;

	assign rdy3      = !valid_s3 || out_ready;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = valid_s3;
	assign out_item  = item_s3;

	// residue of the seed: each nibble weighted by 16^j mod m
	for (genvar j = 0; j < NIBS; j++) begin : g_term
		localparam int unsigned W = (1 << (4 * j)) % M;
		assign term[j] = 8'(item_s1.seed[4*j +: 4]) * 8'(W);
	end

	always_comb begin
		fold_sum = '0;
		for (int j = 0; j < NIBS; j++) begin
			fold_sum = fold_sum + 11'(term[j]);
		end
	end

	// reduce the folded residue by reciprocal multiply, then swap
	always_comb begin
		recip_prod = 27'(fold_s2) * 27'(R);
		quot       = recip_prod[26:16];
		rem        = fold_s2 - 11'(quot * 11'(M));
		pos        = rem[3:0];
		tab_swp    = item_s2.tab;
		tab_swp[STEP] = item_s2.tab[pos];
		tab_swp[pos]  = item_s2.tab[STEP];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1.seed   <= lcg_increment + 32'(in_item.seed * lcg_multiplier);
			item_s1.digits <= in_item.digits;
			item_s1.tab    <= in_item.tab;
		end
		if (rdy2) begin
			item_s2 <= item_s1;
			fold_s2 <= fold_sum;
		end
		if (rdy3) begin
			item_s3.seed   <= item_s2.seed;
			item_s3.digits <= item_s2.digits;
			item_s3.tab    <= tab_swp;
		end
	end

endmodule

[hw/rtl/pku_digit_map.sv]
// pku_digit_map: maps the received characters through the shuffled table into the output register
// depends on pku_pkg
module pku_digit_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pku_pkg::item_t   in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output pku_pkg::plain_t  plain,
	output logic             bad_digit
);

	logic            valid_q;
	pku_pkg::plain_t plain_q;
	logic            bad_q;
	pku_pkg::plain_t plain_d;
	logic            bad_d;
	logic [7:0]      ch;
	logic [7:0]      offs;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign plain     = plain_q;
	assign bad_digit = bad_q;

	always_comb begin
		bad_d   = 1'b0;
		plain_d = '0;
		ch      = '0;
		offs    = '0;
		for (int k = 0; k < pku_pkg::PIN_LEN; k++) begin
			ch   = in_item.digits[k];
			offs = ch - pku_pkg::ASCII_ZERO;
			if (ch >= pku_pkg::ASCII_ZERO && ch <= pku_pkg::ASCII_NINE) begin
				plain_d[k] = 6'(pku_pkg::ASCII_ZERO) + 6'(in_item.tab[offs[3:0]]);
			end else begin
				plain_d[k] = 6'(pku_pkg::ASCII_ZERO);
				bad_d      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			plain_q <= plain_d;
			bad_q   <= bad_d;
		end
	end

endmodule

[hw/rtl/pin_keypad_unscramble_core.sv]
// pin_keypad_unscramble_core: nine shuffle steps of three register stages each plus the
// output register; throughput one request per cycle while the response side accepts
// each step has its own 32x32 generator multiplier
// stalls on the response side are absorbed stage by stage, empty stages fill up first
// reset clears all valid bits and loads the generator registers with their defaults
// depends on pku_pkg, the channel interfaces, pku_cfg_regs, pku_shuffle_step, pku_digit_map
module pin_keypad_unscramble_core (
	input  logic      clk,
	input  logic      arst_n,
	pku_cfg_if.sink   cfg,
	pku_req_if.sink   req,
	pku_rsp_if.source rsp
);

	logic [31:0]     lcg_multiplier;
	logic [31:0]     lcg_increment;
	pku_pkg::item_t  chain_item [pku_pkg::NUM_STEPS+1];
	logic            chain_valid [pku_pkg::NUM_STEPS+1];
	logic            chain_ready [pku_pkg::NUM_STEPS+1];
	pku_pkg::plain_t plain;

	pku_cfg_regs u_cfg_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.lcg_multiplier (lcg_multiplier),
		.lcg_increment  (lcg_increment)
	);

	assign chain_valid[0]       = req.valid;
	assign req.ready            = chain_ready[0];
	assign chain_item[0].seed   = req.seed;
	assign chain_item[0].digits = {req.scrambled_digit_3, req.scrambled_digit_2,
		req.scrambled_digit_1, req.scrambled_digit_0};
	assign chain_item[0].tab    = pku_pkg::TAB_IDENTITY;

	for (genvar g = 1; g <= pku_pkg::NUM_STEPS; g++) begin : g_step
		pku_shuffle_step #(
			.STEP (g)
		) u_step (
			.clk            (clk),
			.arst_n         (arst_n),
			.lcg_multiplier (lcg_multiplier),
			.lcg_increment  (lcg_increment),
			.in_valid       (chain_valid[g-1]),
			.in_ready       (chain_ready[g-1]),
			.in_item        (chain_item[g-1]),
			.out_valid      (chain_valid[g]),
			.out_ready      (chain_ready[g]),
			.out_item       (chain_item[g])
		);
	end

	pku_digit_map u_digit_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[pku_pkg::NUM_STEPS]),
		.in_ready  (chain_ready[pku_pkg::NUM_STEPS]),
		.in_item   (chain_item[pku_pkg::NUM_STEPS]),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.plain     (plain),
		.bad_digit (rsp.bad_digit)
	);

	assign rsp.plain_digit_0 = plain[0];
	assign rsp.plain_digit_1 = plain[1];
	assign rsp.plain_digit_2 = plain[2];
	assign rsp.plain_digit_3 = plain[3];

endmodule
